FILE: rtl/dsas_pkg.sv
// dsas_pkg: types, codes and the month-length table of the daily start alarm scheduler.
// No dependencies. Used by dsas_calc, the core and the testbench.
package dsas_pkg;

  localparam logic [6:0] MaxYear    = 7'd99;
  localparam logic [6:0] MaxHour    = 7'd23;
  localparam logic [3:0] MonthDec   = 4'd12;
  localparam logic [3:0] MonthFeb   = 4'd2;

  typedef enum logic [1:0] {
    ACT_TIME = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] start_hour;
    logic       hour_given;
  } item_t;

  typedef struct packed {
    logic [1:0] drive_command;
    logic       start_pending;
    logic [6:0] target_year;
    logic [3:0] target_month;
    logic [4:0] target_day;
    logic [4:0] target_hour;
  } result_t;

  typedef struct packed {
    logic [6:0] now_year;
    logic [3:0] now_month;
    logic [4:0] now_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [6:0] due_year;
    logic [3:0] due_month;
    logic [4:0] due_day;
    logic [4:0] due_hour;
    logic       pending;
  } state_t;

  // Days in month; leap year by 4, invalid months have none.
  function automatic logic [4:0] month_len(logic [6:0] y, logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MonthFeb:                                  len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/dsas_in_if.sv
// dsas_in_if: input item channel, valid/ready with the item fields.
// Depends on nothing.
interface dsas_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [6:0] start_hour;
  logic       hour_given;

  modport source (
    output valid, action, year, month, day, hour, minute, start_hour, hour_given,
    input  ready
  );
  modport sink (
    input  valid, action, year, month, day, hour, minute, start_hour, hour_given,
    output ready
  );
endinterface

FILE: rtl/dsas_out_if.sv
// dsas_out_if: result item channel, valid/ready with the result fields.
// Depends on nothing.
interface dsas_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive_command;
  logic       start_pending;
  logic [6:0] target_year;
  logic [3:0] target_month;
  logic [4:0] target_day;
  logic [4:0] target_hour;

  modport source (
    output valid, drive_command, start_pending, target_year, target_month,
           target_day, target_hour,
    input  ready
  );
  modport sink (
    input  valid, drive_command, start_pending, target_year, target_month,
           target_day, target_hour,
    output ready
  );
endinterface

FILE: rtl/daily_start_alarm_scheduler_core.sv
// daily_start_alarm_scheduler_core: top level, input register, state and result register.
// Depends on dsas_pkg, dsas_in_if, dsas_out_if and dsas_calc.
//
//   channel  dir  fields
//   req_i    in   action year month day hour minute start_hour hour_given
//   rsp_o    out  drive_command start_pending target_year target_month target_day target_hour
//
// An item is registered on acceptance, then its result in the result register;
// one item per cycle while the result output is not stalled.
// The clock and calendar state updates as the item moves into the result register.
// A stalled result holds the pipeline; the input register still takes an item while empty.
// Reset clears the clock, the target and the pending flag.
module daily_start_alarm_scheduler_core
  import dsas_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  dsas_in_if.sink          req_i,
  dsas_out_if.source       rsp_o
);

  item_t   item_q;
  logic    item_valid_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    adv;

  assign adv       = item_valid_q && (!res_valid_q || rsp_o.ready);
  assign req_i.ready = !item_valid_q || adv;

  dsas_calc u_calc (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        item_valid_q <= 1'b1;
      end else if (adv) begin
        item_valid_q <= 1'b0;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (rsp_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.action     <= req_i.action;
      item_q.year       <= req_i.year;
      item_q.month      <= req_i.month;
      item_q.day        <= req_i.day;
      item_q.hour       <= req_i.hour;
      item_q.minute     <= req_i.minute;
      item_q.start_hour <= req_i.start_hour;
      item_q.hour_given <= req_i.hour_given;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid         = res_valid_q;
  assign rsp_o.drive_command = res_q.drive_command;
  assign rsp_o.start_pending = res_q.start_pending;
  assign rsp_o.target_year   = res_q.target_year;
  assign rsp_o.target_month  = res_q.target_month;
  assign rsp_o.target_day    = res_q.target_day;
  assign rsp_o.target_hour   = res_q.target_hour;

  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.drive_command == CMD_NONE || res_q.drive_command == CMD_ON
                     || res_q.drive_command == CMD_OFF))
    else $error("undefined drive command");

  a_on_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.drive_command == CMD_ON) |-> !res_q.start_pending)
    else $error("turn-on left a start pending");

  a_unresolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.start_pending && res_q.target_year == 7'd0)
      |-> (state_q.now_year == 7'd0))
    else $error("target date unresolved with a known clock");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without an item");

  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && !adv) |=> item_valid_q)
    else $error("stalled item dropped");

endmodule

FILE: rtl/dsas_calc.sv
// dsas_calc: next state and result for one item (update, schedule, resolve, fire).
// Depends on dsas_pkg.
module dsas_calc
  import dsas_pkg::*;
(
  input  item_t   item_i,
  input  state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  logic       on_sched, on_now, pend1, do_sched, fire;
  logic [6:0] now_y;
  logic [3:0] now_m;
  logic [4:0] now_d, now_h, h, mlen;
  logic [5:0] now_min;
  logic [6:0] sy, due_y;
  logic [3:0] sm, due_m;
  logic [4:0] sd, due_d, due_h;
  logic [1:0] cmd;

  always_comb begin
    on_sched = (item_i.action == ACT_ON) && item_i.hour_given
               && (item_i.start_hour <= MaxHour);
    on_now   = (item_i.action == ACT_ON) && !on_sched;

    if (item_i.action == ACT_TIME) begin
      now_y   = item_i.year;
      now_m   = item_i.month;
      now_d   = item_i.day;
      now_h   = item_i.hour;
      now_min = item_i.minute;
    end else begin
      now_y   = state_i.now_year;
      now_m   = state_i.now_month;
      now_d   = state_i.now_day;
      now_h   = state_i.now_hour;
      now_min = state_i.now_minute;
    end

    pend1    = on_sched ? 1'b1 : (on_now ? 1'b0 : state_i.pending);
    do_sched = (now_y != 7'd0) && pend1 && (on_sched || (state_i.due_year == 7'd0));
    h        = on_sched ? item_i.start_hour[4:0] : state_i.due_hour;

    // today, or tomorrow with month and year rollover (the year saturates at MaxYear)
    mlen = month_len(now_y, now_m);
    sy = now_y;
    sm = now_m;
    sd = now_d;
    if (now_h >= h) begin
      if (now_d >= mlen) begin
        sd = 5'd1;
        if (now_m == MonthDec) begin
          sm = 4'd1;
          sy = (now_y >= MaxYear) ? MaxYear : now_y + 7'd1;
        end else begin
          sm = now_m + 4'd1;
        end
      end else begin
        sd = now_d + 5'd1;
      end
    end

    if (do_sched) begin
      due_y = sy;
      due_m = sm;
      due_d = sd;
      due_h = h;
    end else if (on_sched) begin
      due_y = 7'd0;
      due_m = 4'd0;
      due_d = 5'd0;
      due_h = h;
    end else begin
      due_y = state_i.due_year;
      due_m = state_i.due_month;
      due_d = state_i.due_day;
      due_h = state_i.due_hour;
    end

    fire = pend1 && (due_y != 7'd0)
           && ({now_y, now_m, now_d, now_h, now_min} > {due_y, due_m, due_d, due_h, 6'd0});

    if (fire || on_now)                  cmd = CMD_ON;
    else if (item_i.action == ACT_OFF)   cmd = CMD_OFF;
    else                                 cmd = CMD_NONE;

    state_o.now_year   = now_y;
    state_o.now_month  = now_m;
    state_o.now_day    = now_d;
    state_o.now_hour   = now_h;
    state_o.now_minute = now_min;
    state_o.due_year   = due_y;
    state_o.due_month  = due_m;
    state_o.due_day    = due_d;
    state_o.due_hour   = due_h;
    state_o.pending    = pend1 && !fire;

    result_o.drive_command = cmd;
    result_o.start_pending = pend1 && !fire;
    result_o.target_year   = due_y;
    result_o.target_month  = due_m;
    result_o.target_day    = due_d;
    result_o.target_hour   = due_h;
  end

endmodule

FILE: tb/sv/daily_start_alarm_scheduler_core_test.sv
// Testbench for daily_start_alarm_scheduler_core: a directed run of clock, start and stop items,
// then random well-formed calendars with noise, each status checked against an alarm tracker.
// Depends on dsas_pkg, dsas_in_if, dsas_out_if and the core.
module daily_start_alarm_scheduler_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dsas_pkg::*;

  localparam logic [1:0] ActSpare = 2'd3;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned TailCycles = 8;

  // Tracks clock, target and armed flag; one expected status per accepted item.
  class alarm_tracker;
    bit [6:0] clk_yr;
    bit [3:0] clk_mo;
    bit [4:0] clk_dy;
    bit [4:0] clk_hr;
    bit [5:0] clk_mn;
    bit [6:0] tgt_yr;
    bit [3:0] tgt_mo;
    bit [4:0] tgt_dy;
    bit [4:0] tgt_hr;
    bit       armed;
    result_t  alarm_status_q[$];
    int unsigned requests, checked, mismatches, scheduled, fired, forced_on, forced_off;

    static function int month_days(int y, int m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        MonthFeb:              return (y % 4 == 0) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Today at h if the hour is still ahead, else tomorrow at h.
    function void set_target(bit [4:0] h);
      if (clk_hr >= h) begin
        if (clk_dy >= month_days(clk_yr, clk_mo)) begin
          if (clk_mo == MonthDec) begin
            tgt_yr = (clk_yr >= MaxYear) ? MaxYear : clk_yr + 7'd1;
            tgt_mo = 4'd1;
          end else begin
            tgt_yr = clk_yr;
            tgt_mo = clk_mo + 4'd1;
          end
          tgt_dy = 5'd1;
        end else begin
          tgt_yr = clk_yr;
          tgt_mo = clk_mo;
          tgt_dy = clk_dy + 5'd1;
        end
      end else begin
        tgt_yr = clk_yr;
        tgt_mo = clk_mo;
        tgt_dy = clk_dy;
      end
      tgt_hr = h;
    endfunction

    function bit clock_past_target();
      if ({clk_yr, clk_mo, clk_dy, clk_hr} != {tgt_yr, tgt_mo, tgt_dy, tgt_hr})
        return {clk_yr, clk_mo, clk_dy, clk_hr} > {tgt_yr, tgt_mo, tgt_dy, tgt_hr};
      return clk_mn != 6'd0;
    endfunction

    function void take_request(item_t it);
      cmd_e cmd;
      cmd = CMD_NONE;
      if (it.action != ActSpare) requests++;
      case (it.action)
        ACT_TIME: begin
          clk_yr = it.year;
          clk_mo = it.month;
          clk_dy = it.day;
          clk_hr = it.hour;
          clk_mn = it.minute;
        end
        ACT_ON: begin
          if (it.hour_given && it.start_hour <= MaxHour) begin
            armed = 1'b1;
            scheduled++;
            if (clk_yr != 7'd0) begin
              set_target(it.start_hour[4:0]);
            end else begin
              tgt_yr = 7'd0;
              tgt_mo = 4'd0;
              tgt_dy = 5'd0;
              tgt_hr = it.start_hour[4:0];
            end
          end else begin
            armed = 1'b0;
            cmd = CMD_ON;
            forced_on++;
          end
        end
        ACT_OFF: begin
          cmd = CMD_OFF;
          forced_off++;
        end
        default: ;
      endcase
      // date left open while the clock was unknown
      if (clk_yr != 7'd0 && armed && tgt_yr == 7'd0) set_target(tgt_hr);
      if (armed && tgt_yr != 7'd0 && clock_past_target()) begin
        cmd = CMD_ON;
        armed = 1'b0;
        fired++;
      end
      alarm_status_q.push_back({cmd, armed, tgt_yr, tgt_mo, tgt_dy, tgt_hr});
    endfunction

    function void match_status(result_t got);
      result_t want;
      checked++;
      if (alarm_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected status: cmd %0d pending %0b target %0d/%0d/%0d %0dh",
                   got.drive_command, got.start_pending, got.target_year,
                   got.target_month, got.target_day, got.target_hour);
        return;
      end
      want = alarm_status_q.pop_front();
      if (got.drive_command !== want.drive_command || got.start_pending !== want.start_pending ||
          got.target_year !== want.target_year || got.target_month !== want.target_month ||
          got.target_day !== want.target_day || got.target_hour !== want.target_hour) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status %0d: expected cmd %0d pending %0b target %0d/%0d/%0d %0dh, %s",
                   checked, want.drive_command, want.start_pending, want.target_year,
                   want.target_month, want.target_day, want.target_hour,
                   $sformatf("got cmd %0d pending %0b target %0d/%0d/%0d %0dh",
                             got.drive_command, got.start_pending, got.target_year,
                             got.target_month, got.target_day, got.target_hour));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  dsas_in_if  req_if();
  dsas_out_if rsp_if();

  daily_start_alarm_scheduler_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  alarm_tracker tracker = new();
  int unsigned idle_in_pct = 6;
  int unsigned idle_out_pct = 67;
  int unsigned quiet_cycles = 0;
  int cal_yr, cal_mo, cal_dy, cal_hr, cal_mn;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= idle_out_pct);
  end

  always @(posedge clk_i) begin : monitor
    item_t   seen;
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      seen = {req_if.action, req_if.year, req_if.month, req_if.day, req_if.hour,
              req_if.minute, req_if.start_hour, req_if.hour_given};
      tracker.take_request(seen);
      moved = 1'b1;
    end
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = {rsp_if.drive_command, rsp_if.start_pending, rsp_if.target_year,
             rsp_if.target_month, rsp_if.target_day, rsp_if.target_hour};
      tracker.match_status(got);
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no item moved for %0d cycles", StallLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic item_t noise_item();
    item_t it;
    it.action     = 2'($urandom_range(3));
    it.year       = 7'($urandom_range(127));
    it.month      = 4'($urandom_range(15));
    it.day        = 5'($urandom_range(31));
    it.hour       = 5'($urandom_range(31));
    it.minute     = 6'($urandom_range(63));
    it.start_hour = 7'($urandom_range(127));
    it.hour_given = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t mk_time(int y, int m, int d, int h, int mn);
    item_t it;
    it = noise_item();
    it.action = ACT_TIME;
    it.year   = 7'(y);
    it.month  = 4'(m);
    it.day    = 5'(d);
    it.hour   = 5'(h);
    it.minute = 6'(mn);
    return it;
  endfunction

  function automatic item_t mk_on(int sh, bit given);
    item_t it;
    it = noise_item();
    it.action     = ACT_ON;
    it.start_hour = 7'(sh);
    it.hour_given = given;
    return it;
  endfunction

  function automatic item_t mk_cmd(logic [1:0] act);
    item_t it;
    it = noise_item();
    it.action = act;
    return it;
  endfunction

  function automatic void advance_calendar(int mins);
    cal_mn += mins;
    while (cal_mn >= 60) begin
      cal_mn -= 60;
      cal_hr++;
    end
    while (cal_hr >= 24) begin
      cal_hr -= 24;
      cal_dy++;
      if (cal_dy > alarm_tracker::month_days(cal_yr, cal_mo)) begin
        cal_dy = 1;
        cal_mo++;
        if (cal_mo > 12) begin
          cal_mo = 1;
          cal_yr = (cal_yr >= 99) ? 1 : cal_yr + 1;
        end
      end
    end
  endfunction

  // Move the calendar close to a month, leap-day or century edge.
  function automatic void jump_calendar();
    case ($urandom_range(3))
      0: begin
        cal_yr = $urandom_range(1, 99);
        cal_mo = $urandom_range(1, 12);
        cal_dy = alarm_tracker::month_days(cal_yr, cal_mo);
      end
      1: begin
        cal_yr = 99;
        cal_mo = 12;
        cal_dy = 31;
      end
      2: begin
        cal_yr = 4 * $urandom_range(1, 24);
        cal_mo = 2;
        cal_dy = $urandom_range(28, 29);
      end
      default: begin
        cal_yr = 4 * $urandom_range(0, 24) + $urandom_range(1, 3);
        cal_mo = 2;
        cal_dy = 28;
      end
    endcase
    cal_hr = $urandom_range(18, 23);
    cal_mn = $urandom_range(59);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    int step;
    it = noise_item();
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(19) == 0) begin
        jump_calendar();
      end else begin
        step = $urandom_range(99);
        if (step < 50) advance_calendar($urandom_range(1, 30));
        else if (step < 85) advance_calendar($urandom_range(30, 300));
        else advance_calendar($urandom_range(300, 2000));
      end
      it = mk_time(cal_yr, cal_mo, cal_dy, cal_hr, cal_mn);
    end else if (pick < 58) begin
      it = mk_time(0, cal_mo, cal_dy, cal_hr, cal_mn);
    end else if (pick < 72) begin
      it = mk_on($urandom_range(23), 1'b1);
    end else if (pick < 80) begin
      it.action = ACT_OFF;
    end else if (pick < 86) begin
      if ($urandom_range(1) == 0) it = mk_on($urandom_range(127), 1'b0);
      else it = mk_on($urandom_range(24, 127), 1'b1);
    end else if (pick < 91) begin
      it.action = ActSpare;
    end
    return it;
  endfunction

  task automatic push_item(input item_t it);
    if ($urandom_range(99) < idle_in_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_in_pct);
    end
    req_if.valid <= 1'b1;
    {req_if.action, req_if.year, req_if.month, req_if.day, req_if.hour,
     req_if.minute, req_if.start_hour, req_if.hour_given} <= it;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic wait_for_quiet();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.alarm_status_q.size() != 0);
  endtask

  initial begin
    item_t it;
    int    sent;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    {req_if.action, req_if.year, req_if.month, req_if.day, req_if.hour,
     req_if.minute, req_if.start_hour, req_if.hour_given} <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(mk_cmd(ACT_OFF));
    push_item(mk_on(12, 1'b0));
    push_item(mk_on(24, 1'b1));
    push_item(mk_on(127, 1'b1));
    push_item(mk_on(7, 1'b1));             // clock unknown: date left open
    push_item(mk_time(0, 5, 10, 9, 0));
    push_item(mk_time(24, 2, 28, 10, 30)); // resolves to leap day
    push_item(mk_time(24, 2, 29, 7, 0));
    push_item(mk_time(24, 2, 29, 7, 1));
    push_item(mk_on(23, 1'b1));
    push_item(mk_on(0, 1'b1));
    push_item(mk_time(99, 12, 31, 23, 59));
    push_item(mk_on(5, 1'b1));             // year held at 99
    push_item(mk_cmd(ActSpare));
    push_item(mk_time(50, 15, 3, 12, 0));
    push_item(mk_on(3, 1'b1));             // month wraps to 0, fires at once
    push_item(mk_time(50, 0, 0, 31, 63));
    push_item(mk_on(23, 1'b1));
    push_item(mk_time(127, 12, 31, 23, 59));
    push_item(mk_on(0, 1'b1));
    push_item(mk_time(23, 2, 28, 20, 0));
    push_item(mk_on(6, 1'b1));
    push_item(mk_time(23, 3, 1, 6, 1));
    push_item(mk_time(23, 4, 30, 12, 0));
    push_item(mk_on(11, 1'b1));
    push_item(mk_on(23, 1'b0));            // cancels the pending start
    wait_for_quiet();

    cal_yr = 23;
    cal_mo = 1;
    cal_dy = 1;
    cal_hr = 8;
    cal_mn = 0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct  = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
      idle_out_pct = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
      sent = 0;
      while (sent < RandomItems / 3) begin
        it = random_item();
        push_item(it);
        if (it.action != ActSpare) sent++;
      end
      wait_for_quiet();
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("run covered %0d requests over three idle mixes: %0d starts armed, %0d fired,",
             tracker.requests, tracker.scheduled, tracker.fired);
    $display("%0d direct on, %0d off; %0d statuses checked, %0d mismatched",
             tracker.forced_on, tracker.forced_off, tracker.checked, tracker.mismatches);
    if (tracker.alarm_status_q.size() != 0)
      $display("%0d statuses never arrived", tracker.alarm_status_q.size());
    if (tracker.mismatches == 0 && tracker.alarm_status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dsas_pkg.sv
rtl/dsas_in_if.sv
rtl/dsas_out_if.sv
rtl/dsas_calc.sv
rtl/daily_start_alarm_scheduler_core.sv
tb/sv/daily_start_alarm_scheduler_core_test.sv
